@@ rtl/palc_pkg.sv @@
// shared constants, types and helpers of the palette layer alpha compositor
`default_nettype none

package palc_pkg;

   // geometry
   localparam int LAYERS        = 4;
   localparam int TABLE_ENTRIES = 256;
   localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int LAYER_W       = 2;
   localparam int INDEX_W       = 8;
   localparam int WORD_W        = 32;

   // pipeline: table read, alpha product, alpha scale, then two stages per layer
   localparam int PIPE_STAGES   = 3 + 2 * LAYERS;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_ENABLE_MASK = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPACITY_0   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPACITY_1   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPACITY_2   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_OPACITY_3   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_LAYER = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_LAYER  = 3'd6;

   // request kinds
   localparam logic ACT_PIXEL = 1'b0;
   localparam logic ACT_LOAD  = 1'b1;

   // running composite of one pixel
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       inited;
   } acc_type;

   // word carried down the pipeline
   typedef struct packed {
      logic [LAYERS-1:0]       idx_ok;
      logic [LAYERS-1:0][23:0] rgb;
      logic [LAYERS-1:0][7:0]  raw_alpha;
      logic [LAYERS-1:0][15:0] prod;
      logic [LAYERS-1:0][7:0]  scaled;
      logic [2:0][15:0]        sum;
      logic                    blend;
      acc_type                 acc;
      logic                    last;
   } pipe_type;

   // exact floor(x / 255) for x below 255 * 256
   function automatic logic [7:0] div255(input logic [15:0] x);
      logic [16:0] t;
      begin
         t = 17'(x) + 17'(x[15:8]) + 17'd1;
         div255 = t[15:8];
      end
   endfunction

endpackage

`default_nettype wire

@@ rtl/palc_ram.sv @@
// one layer colour table: single write port, registered read port
`default_nettype none

module palc_ram
   import palc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WORD_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WORD_W-1:0] rd_data
);

   logic [WORD_W-1:0] table_mem [TABLE_ENTRIES];
   logic [WORD_W-1:0] rd_data_ff;

   // write and registered read; read data holds while rd_en is low
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ rtl/palette_layer_alpha_compositor.sv @@
// top level: colour table lookup and per-layer alpha compositing pipeline
//
// Use of the block:
//   req_ channel carries one word per pixel (req_action low) or one colour
//   table load (req_action high). A load writes its table entry at the edge
//   where it is accepted and gives no rsp_ word; a pixel read in a later
//   word sees it.
//   rsp_ channel gives one word per pixel, in order: red, green, blue,
//   alpha, covered, and image_end as a copy of last_pixel.
//   csr_ channel writes one register per word (index 0 enable mask, 1..4
//   layer opacities, 5 first layer, 6 last layer); it is always ready. The
//   user must write it only while no pixel is in flight; it is not enforced.
// Pipeline: a pixel shows on rsp_ from the last stage and is taken when the
//   receiver is ready. One word may enter every cycle while req_ready is
//   high; the pipeline is a table read stage, two alpha scaling stages and
//   a multiply and divide stage pair per layer, each stage holding one pixel.
// Stalls: each stage holds its pixel when the next one is full, so bubbles
//   close up and req_ready falls only once every stage holds a pixel.
// Reset: clears the stage valids and the registers to their defaults; the
//   colour tables are not cleared and must be loaded before use.
`default_nettype none

module palette_layer_alpha_compositor
   import palc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // pixel and load requests
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic                   req_action,
   input  wire logic [INDEX_W-1:0]     req_layer_index_0,
   input  wire logic [INDEX_W-1:0]     req_layer_index_1,
   input  wire logic [INDEX_W-1:0]     req_layer_index_2,
   input  wire logic [INDEX_W-1:0]     req_layer_index_3,
   input  wire logic                   req_last_pixel,
   input  wire logic [LAYER_W-1:0]     req_table_layer,
   input  wire logic [INDEX_W-1:0]     req_table_entry,
   input  wire logic [WORD_W-1:0]      req_table_word,
   // composited pixels
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [7:0]                  rsp_red,
   output logic [7:0]                  rsp_green,
   output logic [7:0]                  rsp_blue,
   output logic [7:0]                  rsp_alpha,
   output logic                        rsp_covered,
   output logic                        rsp_image_end,
   // register writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   // configuration registers
   logic [LAYERS-1:0]            enable_ff;
   logic [LAYERS-1:0][7:0]       opacity_ff;
   logic [LAYER_W-1:0]           first_layer_ff;
   logic [LAYER_W-1:0]           last_layer_ff;

   // pipeline
   pipe_type                     pipe_ff [PIPE_STAGES];
   pipe_type                     pipe_in [PIPE_STAGES];
   logic [PIPE_STAGES-1:0]       valid_ff;
   logic [PIPE_STAGES-1:0]       valid_in;
   logic [PIPE_STAGES-1:0]       stage_ready;

   // table access
   logic [LAYERS-1:0][INDEX_W-1:0] pix_index;
   logic [LAYERS-1:0][WORD_W-1:0]  rd_word;
   logic [LAYERS-1:0]              wr_en;
   logic                           req_accept;
   logic                           load_ok;

   assign csr_ready = 1'b1;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff      <= '1;
         opacity_ff     <= {LAYERS{8'd255}};
         first_layer_ff <= '0;
         last_layer_ff  <= '1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ENABLE_MASK: enable_ff      <= csr_data[LAYERS-1:0];
            CSR_OPACITY_0:   opacity_ff[0]  <= csr_data;
            CSR_OPACITY_1:   opacity_ff[1]  <= csr_data;
            CSR_OPACITY_2:   opacity_ff[2]  <= csr_data;
            CSR_OPACITY_3:   opacity_ff[3]  <= csr_data;
            CSR_FIRST_LAYER: first_layer_ff <= csr_data[LAYER_W-1:0];
            CSR_LAST_LAYER:  last_layer_ff  <= csr_data[LAYER_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // handshake chain: a stage takes a new word when empty or draining
   always_comb begin
      stage_ready[PIPE_STAGES-1] = !valid_ff[PIPE_STAGES-1] || rsp_ready;
      for (int st = PIPE_STAGES - 2; st >= 0; st--) begin
         stage_ready[st] = !valid_ff[st] || stage_ready[st+1];
      end
   end

   assign req_ready  = stage_ready[0];
   assign req_accept = req_valid && req_ready;
   assign load_ok    = {1'b0, req_table_entry} < (INDEX_W+1)'(TABLE_ENTRIES);

   assign pix_index[0] = req_layer_index_0;
   assign pix_index[1] = req_layer_index_1;
   assign pix_index[2] = req_layer_index_2;
   assign pix_index[3] = req_layer_index_3;

   // colour tables, one memory per layer
   for (genvar k = 0; k < LAYERS; k++) begin : g_table
      assign wr_en[k] = req_accept && (req_action == ACT_LOAD) && load_ok &&
                        (req_table_layer == LAYER_W'(k));

      palc_ram u_ram (
         .clock   (clock),
         .wr_en   (wr_en[k]),
         .wr_addr (req_table_entry[ADDR_W-1:0]),
         .wr_data (req_table_word),
         .rd_en   (req_accept && (req_action == ACT_PIXEL)),
         .rd_addr (pix_index[k][ADDR_W-1:0]),
         .rd_data (rd_word[k])
      );
   end

   // stage 0: table read in flight, keep index range flags and image end
   always_comb begin
      pipe_in[0]      = '0;
      valid_in[0]     = req_valid && (req_action == ACT_PIXEL);
      pipe_in[0].last = req_last_pixel;
      for (int k = 0; k < LAYERS; k++) begin
         pipe_in[0].idx_ok[k] = {1'b0, pix_index[k]} < (INDEX_W+1)'(TABLE_ENTRIES);
      end
   end

   // stage 1: split table words, alpha times opacity
   always_comb begin
      logic [WORD_W-1:0] word;
      pipe_in[1]  = pipe_ff[0];
      valid_in[1] = valid_ff[0];
      for (int k = 0; k < LAYERS; k++) begin
         word                      = pipe_ff[0].idx_ok[k] ? rd_word[k] : '0;
         pipe_in[1].rgb[k]         = word[23:0];
         pipe_in[1].raw_alpha[k]   = word[31:24];
         pipe_in[1].prod[k]        = 16'(word[31:24]) * 16'(opacity_ff[k]);
      end
   end

   // stage 2: scaled alpha
   always_comb begin
      pipe_in[2]     = pipe_ff[1];
      valid_in[2]    = valid_ff[1];
      pipe_in[2].acc = '0;
      pipe_in[2].blend = 1'b0;
      for (int k = 0; k < LAYERS; k++) begin
         pipe_in[2].scaled[k] = div255(pipe_ff[1].prod[k]);
      end
   end

   // per layer: multiply stage then divide stage
   for (genvar k = 0; k < LAYERS; k++) begin : g_layer
      localparam int MUL_ST = 3 + 2 * k;
      localparam int DIV_ST = 4 + 2 * k;

      logic       active;
      logic [7:0] s;
      logic [7:0] t;

      assign active = enable_ff[k] && (opacity_ff[k] != 8'd0) &&
                      (LAYER_W'(k) >= first_layer_ff) && (LAYER_W'(k) <= last_layer_ff);
      assign s = pipe_ff[MUL_ST-1].scaled[k];
      assign t = 8'd255 - s;

      // first contributor sets the colour, later ones form blend products
      always_comb begin
         pipe_in[MUL_ST]       = pipe_ff[MUL_ST-1];
         valid_in[MUL_ST]      = valid_ff[MUL_ST-1];
         pipe_in[MUL_ST].blend = 1'b0;
         if (active && !pipe_ff[MUL_ST-1].acc.inited) begin
            pipe_in[MUL_ST].acc.red    = pipe_ff[MUL_ST-1].rgb[k][7:0];
            pipe_in[MUL_ST].acc.green  = pipe_ff[MUL_ST-1].rgb[k][15:8];
            pipe_in[MUL_ST].acc.blue   = pipe_ff[MUL_ST-1].rgb[k][23:16];
            pipe_in[MUL_ST].acc.alpha  = s;
            pipe_in[MUL_ST].acc.inited = 1'b1;
         end else if (active && (s != 8'd0)) begin
            pipe_in[MUL_ST].blend  = 1'b1;
            pipe_in[MUL_ST].sum[0] =
               16'(pipe_ff[MUL_ST-1].acc.red) * 16'(t) +
               16'(pipe_ff[MUL_ST-1].rgb[k][7:0]) * 16'(s);
            pipe_in[MUL_ST].sum[1] =
               16'(pipe_ff[MUL_ST-1].acc.green) * 16'(t) +
               16'(pipe_ff[MUL_ST-1].rgb[k][15:8]) * 16'(s);
            pipe_in[MUL_ST].sum[2] =
               16'(pipe_ff[MUL_ST-1].acc.blue) * 16'(t) +
               16'(pipe_ff[MUL_ST-1].rgb[k][23:16]) * 16'(s);
            if (pipe_ff[MUL_ST-1].raw_alpha[k] > pipe_ff[MUL_ST-1].acc.alpha) begin
               pipe_in[MUL_ST].acc.alpha = pipe_ff[MUL_ST-1].raw_alpha[k];
            end
         end
      end

      // blend divide by 255
      always_comb begin
         pipe_in[DIV_ST]  = pipe_ff[DIV_ST-1];
         valid_in[DIV_ST] = valid_ff[DIV_ST-1];
         if (pipe_ff[DIV_ST-1].blend) begin
            pipe_in[DIV_ST].acc.red   = div255(pipe_ff[DIV_ST-1].sum[0]);
            pipe_in[DIV_ST].acc.green = div255(pipe_ff[DIV_ST-1].sum[1]);
            pipe_in[DIV_ST].acc.blue  = div255(pipe_ff[DIV_ST-1].sum[2]);
         end
         pipe_in[DIV_ST].blend = 1'b0;
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int st = 0; st < PIPE_STAGES; st++) begin
            if (stage_ready[st]) begin
               valid_ff[st] <= valid_in[st];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int st = 0; st < PIPE_STAGES; st++) begin
         if (stage_ready[st]) begin
            pipe_ff[st] <= pipe_in[st];
         end
      end
   end

   // result word from the last stage
   assign rsp_valid     = valid_ff[PIPE_STAGES-1];
   assign rsp_red       = pipe_ff[PIPE_STAGES-1].acc.red;
   assign rsp_green     = pipe_ff[PIPE_STAGES-1].acc.green;
   assign rsp_blue      = pipe_ff[PIPE_STAGES-1].acc.blue;
   assign rsp_alpha     = pipe_ff[PIPE_STAGES-1].acc.alpha;
   assign rsp_covered   = pipe_ff[PIPE_STAGES-1].acc.inited;
   assign rsp_image_end = pipe_ff[PIPE_STAGES-1].last;

endmodule

`default_nettype wire
